// ----- hw/rtl/iat_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the indexed array table.
package iat_pkg;

   // Table geometry
   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Request and response field widths
   localparam int OPCODE_W = 3;
   localparam int SLOT_W   = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Controller states
   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DECODE,
      CTL_SHIFT_UP,
      CTL_SHIFT_DOWN,
      CTL_SEARCH,
      CTL_READ_WAIT,
      CTL_STORE,
      CTL_DONE
   } ctl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;         // latch request, check it, set the index
      logic step_up;      // read idx-1, move it up one slot next cycle
      logic step_down;    // read idx+1, move it down one slot next cycle
      logic search_step;  // read idx for compare while idx < count
      logic read_slot;    // read the entry at idx
      logic store;        // final write at idx and count update
      logic finish;       // load the response register
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                ok;
      logic                at_slot;
      logic                shift_more;
      logic                search_done;
      logic                rsp_free;
   } dp_stat_type;

endpackage

// ----- hw/rtl/iat_dp.sv -----
// Datapath of the indexed array table: entry memory, count, walk index and response register.
module iat_dp import iat_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [DATA_W-1:0]   req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_found,
   output logic [DATA_W-1:0]   rsp_read_value,
   output logic [COUNT_W-1:0]  rsp_count
);

   // Entry storage; an entry never written since reset reads as zero
   logic [DATA_W-1:0]   mem_ff [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;

   // Request held for the duration of the operation
   logic [OPCODE_W-1:0] op_ff;
   logic [COUNT_W-1:0]  slot_ff;
   logic [DATA_W-1:0]   val_ff;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  idx_ff, idx_in, idx_init;

   logic [DATA_W-1:0]   rdata_ff;
   logic                wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]   wr_addr_ff;
   logic                cmp_pend_ff, cmp_pend_in;
   logic                found_ff, found_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_found_ff;
   logic [DATA_W-1:0]   rsp_read_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [COUNT_W-1:0]  slot_ext;
   logic [COUNT_W:0]    idx_next_wide;
   logic                idx_below_count;
   logic                hit;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [COUNT_W-1:0]  slot_plus;

   assign slot_ext        = COUNT_W'(req_slot);
   assign idx_below_count = idx_ff < count_ff;
   assign idx_next_wide   = {1'b0, idx_ff} + 1'b1;
   assign hit             = cmp_pend_ff && (rdata_ff == val_ff);
   assign slot_plus       = slot_ff + 1'b1;

   // Request check at acceptance and start index of the walk
   always_comb begin
      status_in = ST_OK;
      idx_init  = slot_ext;
      unique case (req_opcode)
         OP_WRITE, OP_READ: begin
            if (slot_ext >= CAP_COUNT) status_in = ST_RANGE;
         end
         OP_INSERT: begin
            idx_init = count_ff;
            if (slot_ext > count_ff)       status_in = ST_RANGE;
            else if (count_ff >= CAP_COUNT) status_in = ST_FULL;
         end
         OP_DELETE: begin
            if (slot_ext >= count_ff) status_in = ST_RANGE;
         end
         OP_SEARCH: begin
            idx_init = '0;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Walk index
   always_comb begin
      priority if (cmd.load)                          idx_in = idx_init;
      else if (cmd.step_up)                           idx_in = idx_ff - 1'b1;
      else if (cmd.step_down)                         idx_in = idx_next_wide[COUNT_W-1:0];
      else if (cmd.search_step && idx_below_count)    idx_in = idx_next_wide[COUNT_W-1:0];
      else                                            idx_in = idx_ff;
   end

   // Memory read port select
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff[ADDR_W-1:0];
      priority if (cmd.step_up) begin
         rd_en   = 1'b1;
         rd_addr = ADDR_W'(idx_ff - 1'b1);
      end else if (cmd.step_down) begin
         rd_en   = 1'b1;
         rd_addr = idx_next_wide[ADDR_W-1:0];
      end else if (cmd.search_step) begin
         rd_en   = idx_below_count;
      end else if (cmd.read_slot) begin
         rd_en   = 1'b1;
      end
   end

   // Memory write port select: a moved entry lands in the cycle after its read
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_addr_ff;
      wr_data = rdata_ff;
      priority if (wr_pend_ff) begin
         wr_en = 1'b1;
      end else if (cmd.store) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[ADDR_W-1:0];
         wr_data = (op_ff == OP_DELETE) ? '0 : val_ff;
      end
   end

   // Count after the final write
   always_comb begin
      count_in = count_ff;
      if (cmd.store) begin
         unique case (op_ff)
            OP_WRITE:  count_in = (slot_plus > count_ff) ? slot_plus : count_ff;
            OP_INSERT: count_in = count_ff + 1'b1;
            OP_DELETE: count_in = count_ff - 1'b1;
            default:   count_in = count_ff;
         endcase
      end
   end

   assign wr_pend_in  = cmd.step_up || cmd.step_down;
   assign cmp_pend_in = cmd.search_step && idx_below_count;
   assign found_in    = cmd.load ? 1'b0 : (found_ff || hit);

   // Response register valid
   always_comb begin
      priority if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   // Entry memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         cmp_pend_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         cmp_pend_ff  <= cmp_pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and walk payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         slot_ff   <= slot_ext;
         val_ff    <= req_value;
         status_ff <= status_in;
      end
      if (wr_pend_in) wr_addr_ff <= idx_ff[ADDR_W-1:0];
      idx_ff <= idx_in;
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_read_ff   <= ((op_ff == OP_READ) && (status_ff == ST_OK)) ? rdata_ff : '0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign stat.op          = op_ff;
   assign stat.ok          = (status_ff == ST_OK);
   assign stat.at_slot     = (idx_ff == slot_ff);
   assign stat.shift_more  = idx_next_wide < {1'b0, count_ff};
   assign stat.search_done = hit || (!idx_below_count && !cmp_pend_ff);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_count      = rsp_count_ff;

   // Checks
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   a_no_raw_hazard: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_pend_ff) |-> (rd_addr != wr_addr_ff))
      else $error("shift reads the slot being written");

   a_found_search: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (op_ff == OP_SEARCH))
      else $error("found flag set outside a search");

endmodule

// ----- hw/rtl/iat_ctrl.sv -----
// Controller state machine of the indexed array table.
module iat_ctrl import iat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= CTL_IDLE;
      else       state_ff <= state_in;
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTL_DECODE;
            end
         end
         CTL_DECODE: begin
            if (!stat.ok) begin
               state_in = CTL_DONE;
            end else begin
               unique case (stat.op)
                  OP_WRITE:  state_in = CTL_STORE;
                  OP_INSERT: state_in = CTL_SHIFT_UP;
                  OP_DELETE: state_in = CTL_SHIFT_DOWN;
                  OP_SEARCH: state_in = CTL_SEARCH;
                  OP_READ: begin
                     cmd.read_slot = 1'b1;
                     state_in      = CTL_READ_WAIT;
                  end
                  default:   state_in = CTL_DONE;
               endcase
            end
         end
         CTL_SHIFT_UP: begin
            if (stat.at_slot) state_in = CTL_STORE;
            else              cmd.step_up = 1'b1;
         end
         CTL_SHIFT_DOWN: begin
            if (stat.shift_more) cmd.step_down = 1'b1;
            else                 state_in = CTL_STORE;
         end
         CTL_SEARCH: begin
            if (stat.search_done) state_in = CTL_DONE;
            else                  cmd.search_step = 1'b1;
         end
         CTL_READ_WAIT: begin
            state_in = CTL_DONE;
         end
         CTL_STORE: begin
            cmd.store = 1'b1;
            state_in  = CTL_DONE;
         end
         CTL_DONE: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/indexed_array_table.sv -----
// Indexed array table: write, insert, delete, search and read on a 16-entry array of unsigned 32-bit values.
// Insert and delete shift the entries between slot and count; a search walks from slot 0 up to count.
// One request in flight; the entry memory's single read and write port move one entry a cycle.
// Throughput: a new request is taken once the previous one has loaded the response register.
// Reset is synchronous and clears the count and the entry valid bits, so entries then read as zero.
module indexed_array_table import iat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[2:0], slot[6:3], item_value[38:7], zero[39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], found[2], read_value[34:3], entry_count[39:35]
);

   dp_cmd_type          cmd;
   dp_stat_type         stat;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_found;
   logic [DATA_W-1:0]   rsp_read_value;
   logic [COUNT_W-1:0]  rsp_count;

   iat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   iat_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_tdata[2:0]),
      .req_slot       (req_tdata[6:3]),
      .req_value      (req_tdata[38:7]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   // Response packing
   assign rsp_tdata = {rsp_count, rsp_read_value, rsp_found, rsp_status};

endmodule
